[sv/rmlp_pkg.sv]
package rmlp_pkg;

    typedef enum logic [1:0] {
        KIND_PREFIX,
        KIND_RX,
        KIND_LEN,
        KIND_IGNORE
    } line_kind_t;

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_TAG,
        PH_VALUE
    } pair_phase_t;

    typedef struct packed {
        logic started;
        logic neg;
        logic stopped;
    } value_flags_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [15:0]        device_id;
        logic [7:0]         sequence_res;
        logic [7:0]         lock_state;
        logic [7:0]         charge_byte;
        logic signed [15:0] link_rssi;
        logic signed [15:0] link_snr;
    } core_result_t;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_BAD_LENGTH = 2'd1;
    localparam logic [1:0] STATUS_BAD_HEADER = 2'd2;

    localparam logic CFG_HEADER_FIRST  = 1'b0;
    localparam logic CFG_HEADER_SECOND = 1'b1;

    localparam logic [7:0] HEADER_FIRST_RESET  = 8'h38;
    localparam logic [7:0] HEADER_SECOND_RESET = 8'h05;
    localparam logic signed [15:0] RSSI_DEFAULT = -16'sd99;
    localparam logic signed [15:0] SNR_DEFAULT  = 16'sd0;

    localparam logic [3:0] PAYLOAD_CHARS = 4'd14;
    localparam logic [3:0] COUNT_MAX     = 4'd15;

    localparam logic [3:0] TAG_START = 4'd0;
    localparam logic [3:0] TAG_RSSI  = 4'd4;
    localparam logic [3:0] TAG_SNR   = 4'd7;
    localparam logic [3:0] TAG_OTHER = 4'd15;

    localparam logic [15:0] ACC_SAT  = 16'd32768;
    localparam logic [15:0] POS_MAX  = 16'd32767;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_QUOTE = 8'h22;
    localparam logic [7:0] CHAR_PLUS  = 8'h2b;
    localparam logic [7:0] CHAR_COMMA = 8'h2c;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_COLON = 8'h3a;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_E  = 8'h45;
    localparam logic [7:0] CHAR_UP_F  = 8'h46;
    localparam logic [7:0] CHAR_UP_I  = 8'h49;
    localparam logic [7:0] CHAR_UP_L  = 8'h4c;
    localparam logic [7:0] CHAR_UP_N  = 8'h4e;
    localparam logic [7:0] CHAR_UP_R  = 8'h52;
    localparam logic [7:0] CHAR_UP_S  = 8'h53;
    localparam logic [7:0] CHAR_UP_X  = 8'h58;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_LO_F  = 8'h66;

    // atoi result with 16 bit saturation
    function automatic logic signed [15:0] value_to_signed(input logic [15:0] acc,
                                                           input logic neg);
        logic [15:0] mag;
        mag = (acc > POS_MAX) ? POS_MAX : acc;
        if (neg)
        begin
            return $signed(16'(~acc + 16'd1));
        end
        return $signed(mag);
    endfunction

endpackage

[sv/rmlp_value_unit.sv]
module rmlp_value_unit #(
    parameter int VALUE_CHAR_LIMIT = 31,
    parameter int LEN_W = 5
) (
    input  logic [7:0]           ch,
    input  logic [15:0]          acc,
    input  rmlp_pkg::value_flags_t flags,
    input  logic [LEN_W-1:0]     len,
    output logic [15:0]          acc_next,
    output rmlp_pkg::value_flags_t flags_next,
    output logic [LEN_W-1:0]     len_next
);

    logic        is_digit;
    logic        is_blank;
    logic [18:0] acc_wide;

    assign is_digit = ch inside {[rmlp_pkg::CHAR_ZERO:rmlp_pkg::CHAR_NINE]};
    assign is_blank = (ch == rmlp_pkg::CHAR_SPACE) ||
                      (ch inside {[rmlp_pkg::CHAR_TAB:rmlp_pkg::CHAR_CR]});
    assign acc_wide = {acc, 3'b000} + {2'b00, acc, 1'b0}
                    + {15'd0, 4'(ch - rmlp_pkg::CHAR_ZERO)};

    always_comb
    begin
        acc_next   = acc;
        flags_next = flags;
        len_next   = len;
        if (len < LEN_W'(VALUE_CHAR_LIMIT))
        begin
            len_next = len + LEN_W'(1);
            if (!flags.stopped)
            begin
                if (!flags.started && is_blank)
                begin
                    // leading white space is skipped
                end
                else if (!flags.started && (ch == rmlp_pkg::CHAR_MINUS))
                begin
                    flags_next.started = 1'b1;
                    flags_next.neg     = 1'b1;
                end
                else if (!flags.started && (ch == rmlp_pkg::CHAR_PLUS))
                begin
                    flags_next.started = 1'b1;
                end
                else if (is_digit)
                begin
                    flags_next.started = 1'b1;
                    acc_next = (acc_wide > {3'd0, rmlp_pkg::ACC_SAT}) ?
                               rmlp_pkg::ACC_SAT : acc_wide[15:0];
                end
                else
                begin
                    flags_next.started = 1'b1;
                    flags_next.stopped = 1'b1;
                end
            end
        end
    end

endmodule

[sv/rmlp_charge_calc.sv]
module rmlp_charge_calc (
    input  logic [7:0] charge_byte,
    output logic [6:0] charge_percent
);

    logic [14:0] prod;
    logic [22:0] scaled;
    logic [6:0]  q_est;
    logic [14:0] back;
    logic [14:0] rem;

    // byte * 100, then / 255 via * 257 / 65536 with one correction step
    assign prod   = {1'b0, charge_byte, 6'd0} + {2'b00, charge_byte, 5'd0}
                  + {5'd0, charge_byte, 2'd0};
    assign scaled = {prod, 8'd0} + {8'd0, prod};
    assign q_est  = scaled[22:16];
    assign back   = {q_est, 8'd0} - {8'd0, q_est};
    assign rem    = prod - back;
    assign charge_percent = (rem >= 15'd255) ? (q_est + 7'd1) : q_est;

endmodule

[sv/rmlp_line_core.sv]
module rmlp_line_core #(
    parameter int VALUE_CHAR_LIMIT = 31,
    parameter int LEN_W = 5
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  logic [7:0]                 ch,
    input  logic                       line_end,
    input  logic [7:0]                 header_first_byte,
    input  logic [7:0]                 header_second_byte,
    output logic                       result_valid,
    output rmlp_pkg::core_result_t     result
);

    rmlp_pkg::line_kind_t   kind_reg, kind_next;
    logic [2:0]             pp_reg, pp_next;
    logic [3:0]             cnt_reg, cnt_next;
    logic [3:0]             hn_reg, hn_next;
    logic                   closed_reg, closed_next;
    rmlp_pkg::pair_phase_t  ph_reg, ph_next;
    logic [3:0]             tm_reg, tm_next;
    logic [15:0]            acc_reg, acc_next;
    rmlp_pkg::value_flags_t fl_reg, fl_next;
    logic [LEN_W-1:0]       vlen_reg, vlen_next;
    logic signed [15:0]     rssi_reg, rssi_next;
    logic signed [15:0]     snr_reg, snr_next;

    logic [7:0]             bytes_reg [7];
    logic [7:0]             bytes_view [7];
    logic                   wr_en;
    logic [2:0]             wr_idx;
    logic [7:0]             wr_data;

    logic [15:0]            vu_acc;
    rmlp_pkg::value_flags_t vu_flags;
    logic [LEN_W-1:0]       vu_len;

    logic                   do_apply;
    logic [3:0]             tag_cur;
    logic [3:0]             nib;
    logic signed [15:0]     value_s;

    function automatic logic [3:0] hex_digit(input logic [7:0] c);
        logic [3:0] d;
        d = 4'd0;
        if (c inside {[rmlp_pkg::CHAR_ZERO:rmlp_pkg::CHAR_NINE]})
        begin
            d = 4'(c - rmlp_pkg::CHAR_ZERO);
        end
        else if (c inside {[rmlp_pkg::CHAR_UP_A:rmlp_pkg::CHAR_UP_F]})
        begin
            d = 4'(c - rmlp_pkg::CHAR_UP_A + 8'd10);
        end
        else if (c inside {[rmlp_pkg::CHAR_LO_A:rmlp_pkg::CHAR_LO_F]})
        begin
            d = 4'(c - rmlp_pkg::CHAR_LO_A + 8'd10);
        end
        return d;
    endfunction

    function automatic logic [3:0] tag_step(input logic [3:0] t, input logic [7:0] c);
        logic [3:0] n;
        n = rmlp_pkg::TAG_OTHER;
        case (t)
            4'd0:    n = (c == rmlp_pkg::CHAR_UP_R) ? 4'd1 :
                         ((c == rmlp_pkg::CHAR_UP_S) ? 4'd5 : rmlp_pkg::TAG_OTHER);
            4'd1:    n = (c == rmlp_pkg::CHAR_UP_S) ? 4'd2 : rmlp_pkg::TAG_OTHER;
            4'd2:    n = (c == rmlp_pkg::CHAR_UP_S) ? 4'd3 : rmlp_pkg::TAG_OTHER;
            4'd3:    n = (c == rmlp_pkg::CHAR_UP_I) ? 4'd4 : rmlp_pkg::TAG_OTHER;
            4'd5:    n = (c == rmlp_pkg::CHAR_UP_N) ? 4'd6 : rmlp_pkg::TAG_OTHER;
            4'd6:    n = (c == rmlp_pkg::CHAR_UP_R) ? 4'd7 : rmlp_pkg::TAG_OTHER;
            default: n = rmlp_pkg::TAG_OTHER;
        endcase
        return n;
    endfunction

    // expected rx prefix character at a given position (R X space quote)
    function automatic logic [7:0] rx_prefix(input logic [1:0] p);
        logic [7:0] c;
        case (p)
            2'd0:    c = rmlp_pkg::CHAR_UP_R;
            2'd1:    c = rmlp_pkg::CHAR_UP_X;
            2'd2:    c = rmlp_pkg::CHAR_SPACE;
            default: c = rmlp_pkg::CHAR_QUOTE;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] len_prefix(input logic [1:0] p);
        logic [7:0] c;
        case (p)
            2'd0:    c = rmlp_pkg::CHAR_UP_L;
            2'd1:    c = rmlp_pkg::CHAR_UP_E;
            2'd2:    c = rmlp_pkg::CHAR_UP_N;
            default: c = rmlp_pkg::CHAR_COLON;
        endcase
        return c;
    endfunction

    rmlp_value_unit #(
        .VALUE_CHAR_LIMIT(VALUE_CHAR_LIMIT),
        .LEN_W(LEN_W)
    ) u_value (
        .ch(ch),
        .acc(acc_reg),
        .flags(fl_reg),
        .len(vlen_reg),
        .acc_next(vu_acc),
        .flags_next(vu_flags),
        .len_next(vu_len)
    );

    always_comb
    begin
        for (int i = 0; i < 7; i++)
        begin
            bytes_view[i] = (wr_en && (wr_idx == 3'(i))) ? wr_data : bytes_reg[i];
        end
    end

    always_comb
    begin
        kind_next    = kind_reg;
        pp_next      = pp_reg;
        cnt_next     = cnt_reg;
        hn_next      = hn_reg;
        closed_next  = closed_reg;
        ph_next      = ph_reg;
        tm_next      = tm_reg;
        acc_next     = acc_reg;
        fl_next      = fl_reg;
        vlen_next    = vlen_reg;
        rssi_next    = rssi_reg;
        snr_next     = snr_reg;
        wr_en        = 1'b0;
        wr_idx       = cnt_reg[3:1];
        nib          = hex_digit(ch);
        wr_data      = {hn_reg, nib};
        do_apply     = 1'b0;
        tag_cur      = (ph_reg == rmlp_pkg::PH_SKIP) ? rmlp_pkg::TAG_START : tm_reg;
        result_valid = 1'b0;
        result       = '0;

        case (kind_reg)
            rmlp_pkg::KIND_PREFIX:
            begin
                if (ch == rmlp_pkg::CHAR_NUL)
                begin
                    kind_next = rmlp_pkg::KIND_IGNORE;
                end
                else if (pp_reg == 3'd0)
                begin
                    if (ch == rmlp_pkg::CHAR_UP_R)
                    begin
                        pp_next = 3'd1;
                    end
                    else if (ch == rmlp_pkg::CHAR_UP_L)
                    begin
                        pp_next = 3'd5;
                    end
                    else
                    begin
                        kind_next = rmlp_pkg::KIND_IGNORE;
                    end
                end
                else if (!pp_reg[2])
                begin
                    if (ch != rx_prefix(pp_reg[1:0]))
                    begin
                        kind_next = rmlp_pkg::KIND_IGNORE;
                    end
                    else
                    begin
                        pp_next = pp_reg + 3'd1;
                        if (pp_reg[1:0] == 2'd3)
                        begin
                            kind_next = rmlp_pkg::KIND_RX;
                        end
                    end
                end
                else
                begin
                    if (ch != len_prefix(pp_reg[1:0]))
                    begin
                        kind_next = rmlp_pkg::KIND_IGNORE;
                    end
                    else
                    begin
                        pp_next = pp_reg + 3'd1;
                        if (pp_reg[1:0] == 2'd3)
                        begin
                            // the whole line is pairs, the first tag being LEN
                            kind_next = rmlp_pkg::KIND_LEN;
                            tm_next   = rmlp_pkg::TAG_OTHER;
                            ph_next   = rmlp_pkg::PH_VALUE;
                            acc_next  = '0;
                            fl_next   = '0;
                            vlen_next = '0;
                        end
                    end
                end
            end
            rmlp_pkg::KIND_RX:
            begin
                if (!closed_reg)
                begin
                    if ((ch == rmlp_pkg::CHAR_QUOTE) || (ch == rmlp_pkg::CHAR_NUL))
                    begin
                        closed_next = 1'b1;
                    end
                    else
                    begin
                        if (cnt_reg < rmlp_pkg::PAYLOAD_CHARS)
                        begin
                            if (!cnt_reg[0])
                            begin
                                hn_next = nib;
                            end
                            else
                            begin
                                wr_en = 1'b1;
                            end
                        end
                        if (cnt_reg < rmlp_pkg::COUNT_MAX)
                        begin
                            cnt_next = cnt_reg + 4'd1;
                        end
                    end
                end
            end
            rmlp_pkg::KIND_LEN:
            begin
                if (ch == rmlp_pkg::CHAR_NUL)
                begin
                    do_apply  = (ph_reg == rmlp_pkg::PH_VALUE);
                    kind_next = rmlp_pkg::KIND_IGNORE;
                end
                else if (ph_reg == rmlp_pkg::PH_VALUE)
                begin
                    if (ch == rmlp_pkg::CHAR_COMMA)
                    begin
                        do_apply = 1'b1;
                        ph_next  = rmlp_pkg::PH_SKIP;
                    end
                    else
                    begin
                        acc_next  = vu_acc;
                        fl_next   = vu_flags;
                        vlen_next = vu_len;
                    end
                end
                else if ((ph_reg == rmlp_pkg::PH_SKIP) && (ch == rmlp_pkg::CHAR_SPACE))
                begin
                    // leading spaces before a tag
                end
                else
                begin
                    tm_next = tag_cur;
                    if (ch == rmlp_pkg::CHAR_COLON)
                    begin
                        ph_next   = rmlp_pkg::PH_VALUE;
                        acc_next  = '0;
                        fl_next   = '0;
                        vlen_next = '0;
                    end
                    else
                    begin
                        ph_next = rmlp_pkg::PH_TAG;
                        tm_next = tag_step(tag_cur, ch);
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (line_end && (kind_next == rmlp_pkg::KIND_LEN) &&
            (ph_next == rmlp_pkg::PH_VALUE))
        begin
            do_apply = 1'b1;
        end

        value_s = rmlp_pkg::value_to_signed(acc_next, fl_next.neg);
        if (do_apply)
        begin
            if (tm_next == rmlp_pkg::TAG_RSSI)
            begin
                rssi_next = value_s;
            end
            else if (tm_next == rmlp_pkg::TAG_SNR)
            begin
                snr_next = value_s;
            end
        end

        if (line_end && (kind_next == rmlp_pkg::KIND_RX))
        begin
            result_valid = 1'b1;
            if (cnt_next != rmlp_pkg::PAYLOAD_CHARS)
            begin
                result.status = rmlp_pkg::STATUS_BAD_LENGTH;
            end
            else if ((bytes_view[0] != header_first_byte) ||
                     (bytes_view[1] != header_second_byte))
            begin
                result.status = rmlp_pkg::STATUS_BAD_HEADER;
            end
            else
            begin
                result.status       = rmlp_pkg::STATUS_OK;
                result.device_id    = {bytes_view[2], bytes_view[3]};
                result.sequence_res = bytes_view[4];
                result.lock_state   = bytes_view[5];
                result.charge_byte  = bytes_view[6];
                result.link_rssi    = rssi_reg;
                result.link_snr     = snr_reg;
                rssi_next           = rmlp_pkg::RSSI_DEFAULT;
                snr_next            = rmlp_pkg::SNR_DEFAULT;
            end
        end

        if (line_end)
        begin
            kind_next   = rmlp_pkg::KIND_PREFIX;
            pp_next     = 3'd0;
            cnt_next    = 4'd0;
            hn_next     = 4'd0;
            closed_next = 1'b0;
            ph_next     = rmlp_pkg::PH_SKIP;
            tm_next     = rmlp_pkg::TAG_START;
            acc_next    = '0;
            fl_next     = '0;
            vlen_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg   <= rmlp_pkg::KIND_PREFIX;
            pp_reg     <= 3'd0;
            cnt_reg    <= 4'd0;
            hn_reg     <= 4'd0;
            closed_reg <= 1'b0;
            ph_reg     <= rmlp_pkg::PH_SKIP;
            tm_reg     <= rmlp_pkg::TAG_START;
            acc_reg    <= '0;
            fl_reg     <= '0;
            vlen_reg   <= '0;
            rssi_reg   <= rmlp_pkg::RSSI_DEFAULT;
            snr_reg    <= rmlp_pkg::SNR_DEFAULT;
        end
        else if (step)
        begin
            kind_reg   <= kind_next;
            pp_reg     <= pp_next;
            cnt_reg    <= cnt_next;
            hn_reg     <= hn_next;
            closed_reg <= closed_next;
            ph_reg     <= ph_next;
            tm_reg     <= tm_next;
            acc_reg    <= acc_next;
            fl_reg     <= fl_next;
            vlen_reg   <= vlen_next;
            rssi_reg   <= rssi_next;
            snr_reg    <= snr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && wr_en)
        begin
            bytes_reg[wr_idx] <= wr_data;
        end
    end

    a_closed_only_in_rx: assert property (@(posedge clk) disable iff (!rst_n)
        closed_reg |-> (kind_reg == rmlp_pkg::KIND_RX))
        else $error("payload closed outside an rx line");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != 4'd0) |-> (kind_reg == rmlp_pkg::KIND_RX))
        else $error("payload count set outside an rx line");

    a_line_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (step && line_end) |=> (kind_reg == rmlp_pkg::KIND_PREFIX) && (pp_reg == 3'd0))
        else $error("line state not cleared after line end");

    a_value_len_limit: assert property (@(posedge clk) disable iff (!rst_n)
        vlen_reg <= LEN_W'(VALUE_CHAR_LIMIT))
        else $error("value length past its limit");

endmodule

[sv/radio_modem_line_parser_top.sv]
// Radio modem line parser. Takes one ASCII character per beat on s_* (tlast on the
// last character of a line) and gives at most one result per line on m_*: only an
// RX "hex" line yields a result, with its status in m_tuser and, when the status is
// ok, the decoded id, sequence, lock byte, charge percent and the stored rssi/snr in
// m_tdata (all zero otherwise). LEN: lines update the stored rssi and snr from their
// RSSI and SNR pairs; an ok result resets them to -99 and 0. One character is taken
// every cycle unless the input stalls; it passes the input register and its result
// the result register. The input stalls only while the result register is still
// full and the next character ends an RX line. The user must write the two header
// registers through cfg_* only while no line is in flight; the block does not enforce it.
module radio_modem_line_parser_top #(
    parameter int VALUE_CHAR_LIMIT = 31
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // char_code
    input  logic        s_tlast,   // line_end

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // device_id, sequence_res, lock_state,
                                   // charge_percent, link_rssi, link_snr, zero pad
    output logic [1:0]  m_tuser,   // status

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int LEN_W = $clog2(VALUE_CHAR_LIMIT + 1);

    logic                   in_valid_reg;
    logic [7:0]             in_char_reg;
    logic                   in_last_reg;
    logic                   core_take;
    logic                   core_result_valid;
    rmlp_pkg::core_result_t core_result;
    logic [6:0]             charge_percent;
    logic                   out_free;

    logic                   out_valid_reg;
    logic [1:0]             out_status_reg;
    logic [70:0]            out_data_reg;

    logic [7:0]             header_first_reg;
    logic [7:0]             header_second_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_first_reg  <= rmlp_pkg::HEADER_FIRST_RESET;
            header_second_reg <= rmlp_pkg::HEADER_SECOND_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rmlp_pkg::CFG_HEADER_FIRST:  header_first_reg  <= cfg_data;
                rmlp_pkg::CFG_HEADER_SECOND: header_second_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign out_free  = !out_valid_reg || m_tready;
    assign core_take = in_valid_reg && (!core_result_valid || out_free);
    assign s_tready  = !in_valid_reg || core_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    rmlp_line_core #(
        .VALUE_CHAR_LIMIT(VALUE_CHAR_LIMIT),
        .LEN_W(LEN_W)
    ) u_core (
        .clk(clk),
        .rst_n(rst_n),
        .step(core_take),
        .ch(in_char_reg),
        .line_end(in_last_reg),
        .header_first_byte(header_first_reg),
        .header_second_byte(header_second_reg),
        .result_valid(core_result_valid),
        .result(core_result)
    );

    rmlp_charge_calc u_charge (
        .charge_byte(core_result.charge_byte),
        .charge_percent(charge_percent)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (core_take && core_result_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_take && core_result_valid)
        begin
            out_status_reg <= core_result.status;
            out_data_reg   <= {core_result.link_snr, core_result.link_rssi, charge_percent,
                               core_result.lock_state, core_result.sequence_res,
                               core_result.device_id};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {1'b0, out_data_reg};

    a_error_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != rmlp_pkg::STATUS_OK)) |-> (m_tdata == 72'd0))
        else $error("fields not zero on an error result");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == rmlp_pkg::STATUS_OK) ||
                     (m_tuser == rmlp_pkg::STATUS_BAD_LENGTH) ||
                     (m_tuser == rmlp_pkg::STATUS_BAD_HEADER))
        else $error("status code out of range");

    a_charge_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[38:32] <= 7'd100))
        else $error("charge percent above 100");

    a_empty_input_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("input register empty but not ready");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !(core_take && core_result_valid))
        else $error("result register overwritten while held");

endmodule
